[src/wca_pkg.sv]
// ----------------------------------------------------------------------------
// wca_pkg: shared types and constants of the wormhole crossbar allocator
// Port counts, action and phase codes, and the controller/datapath link.
// ----------------------------------------------------------------------------
`default_nettype none

package wca_pkg;

  localparam int NumInputs  = 8;
  localparam int NumOutputs = 8;
  localparam int WaitDepth  = 8;
  localparam int InIdxW     = $clog2(NumInputs);
  localparam int OutIdxW    = $clog2(NumOutputs);
  localparam int QPtrW      = $clog2(WaitDepth);
  localparam int QCntW      = QPtrW + 1;
  localparam int QAddrW     = OutIdxW + QPtrW;
  localparam int QDepth     = NumOutputs * WaitDepth;

  localparam logic [1:0] OpFlit  = 2'd0;
  localparam logic [1:0] OpRaise = 2'd1;
  localparam logic [1:0] OpLower = 2'd2;

  localparam logic [2:0] ActFwd     = 3'd0;
  localparam logic [2:0] ActQueued  = 3'd1;
  localparam logic [2:0] ActHeld    = 3'd2;
  localparam logic [2:0] ActStop    = 3'd3;
  localparam logic [2:0] ActRelease = 3'd4;
  localparam logic [2:0] ActNothing = 3'd5;
  localparam logic [2:0] ActError   = 3'd6;

  localparam logic [1:0] PhFree = 2'd0;
  localparam logic [1:0] PhWait = 2'd1;
  localparam logic [1:0] PhConn = 2'd2;

  typedef struct packed {
    logic       load;   // capture an input item
    logic       eval;   // process captured item (queue head read valid)
  } wca_cmd_t;

  typedef struct packed {
    logic       grant;  // evaluation produced a second result
  } wca_sts_t;

endpackage

`default_nettype wire

[src/wca_ram.sv]
// ----------------------------------------------------------------------------
// wca_ram: generic single-port-write, single-read RAM with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module wca_ram #(
  parameter int Width = 4,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[src/wca_ctrl.sv]
// ----------------------------------------------------------------------------
// wca_ctrl: sequencer of the allocator
// Capture an item, wait in the read state for the registered queue read,
// evaluate, then drain one or two results to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module wca_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output wca_pkg::wca_cmd_t  cmd_o,
  input  wire wca_pkg::wca_sts_t sts_i,
  output logic               sel_second_o
);
  import wca_pkg::*;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRead  = 5'b00010,
    StEval  = 5'b00100,
    StOut1  = 5'b01000,
    StOut2  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   two_q, two_d;

  assign in_stall     = (state_q != StIdle);
  assign out_valid    = (state_q == StOut1) || (state_q == StOut2);
  assign sel_second_o = (state_q == StOut2);
  assign cmd_o.load   = (state_q == StIdle) && in_valid;
  assign cmd_o.eval   = (state_q == StEval);

  always_comb begin
    state_d = state_q;
    two_d   = two_q;
    case (state_q)
      StIdle: if (in_valid) state_d = StRead;
      StRead: state_d = StEval;
      StEval: begin
        two_d   = sts_i.grant;
        state_d = StOut1;
      end
      StOut1: if (!out_stall) state_d = two_q ? StOut2 : StIdle;
      StOut2: if (!out_stall) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      two_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      two_q   <= two_d;
    end
  end

endmodule

`default_nettype wire

[src/wca_dp.sv]
// ----------------------------------------------------------------------------
// wca_dp: allocation tables, wait queues and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module wca_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wca_pkg::wca_cmd_t cmd_i,
  output wca_pkg::wca_sts_t      sts_o,
  input  wire logic              sel_second_i,
  input  wire logic [1:0]        op_i,
  input  wire logic [3:0]        port_i,
  input  wire logic [3:0]        dest_port_i,
  input  wire logic              is_tail_i,
  output logic [2:0]             action_o,
  output logic [3:0]             in_port_o,
  output logic [3:0]             out_port_o,
  output logic                   input_stop_o,
  output logic                   last_o
);
  import wca_pkg::*;

  logic [1:0] op_q;
  logic [3:0] port_q, dest_q;
  logic       tail_q;

  logic [3:0]       owner_q  [NumOutputs];
  logic [3:0]       outof_q  [NumInputs];
  logic [1:0]       phase_q  [NumInputs];
  logic [QPtrW-1:0] head_q   [NumOutputs];
  logic [QCntW-1:0] count_q  [NumOutputs];
  logic             stop_q   [NumOutputs];

  // result registers: first and second
  logic [2:0] act1_q;
  logic [3:0] ip1_q, op1_q, ip2_q, op2_q;
  logic       st1_q, two_q;

  logic [3:0]   qrdata;
  logic         q_we;
  logic [QAddrW-1:0] q_waddr, q_raddr;

  // queue head address of the routed output for the captured item
  logic [OutIdxW-1:0] rt_oi;
  logic [InIdxW-1:0]  pi;
  logic [3:0]         conn;
  assign pi    = InIdxW'(port_q - 4'd1);
  assign conn  = (outof_q[pi] != 4'd0) ? outof_q[pi] : dest_q;
  assign rt_oi = OutIdxW'(conn - 4'd1);
  assign q_raddr = {rt_oi, head_q[rt_oi]};

  wca_ram #(.Width(4), .Depth(QDepth)) u_queue (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(q_waddr),
    .wdata_i(port_q),
    .raddr_i(q_raddr),
    .rdata_o(qrdata)
  );

  // evaluation decode
  logic [2:0] act;
  logic [3:0] rip, rop;
  logic       rstop, grant;
  logic       take, fwd, rel, enq, set_stop;
  logic [OutIdxW-1:0] oi, si;
  logic [InIdxW-1:0]  ni;
  logic [QPtrW-1:0]   tailp;

  always_comb begin
    act = ActNothing; rip = 4'd0; rop = 4'd0; rstop = 1'b0; grant = 1'b0;
    take = 1'b0; fwd = 1'b0; rel = 1'b0; enq = 1'b0; set_stop = 1'b0;
    oi = OutIdxW'(dest_q - 4'd1);
    si = OutIdxW'(port_q - 4'd1);
    ni = InIdxW'(qrdata - 4'd1);
    tailp = head_q[oi] + QPtrW'(count_q[oi]);
    case (op_q)
      OpFlit: begin
        rip = port_q;
        if (port_q == 4'd0 || port_q > 4'(NumInputs)) begin
          act = ActError;
        end else if (outof_q[pi] == 4'd0 && phase_q[pi] == PhWait) begin
          act = ActHeld; rstop = 1'b1;
        end else if (outof_q[pi] == 4'd0 &&
                     (dest_q == 4'd0 || dest_q > 4'(NumOutputs))) begin
          act = ActError; rop = dest_q;
        end else if (outof_q[pi] == 4'd0 && owner_q[oi] != 4'd0) begin
          rop = dest_q; rstop = 1'b1;
          if (count_q[oi] >= QCntW'(WaitDepth)) begin
            act = ActHeld;
          end else begin
            act = ActQueued; enq = 1'b1;
          end
        end else begin
          take = (outof_q[pi] == 4'd0);
          oi   = rt_oi;
          rop  = conn;
          if (stop_q[oi]) begin
            act = ActHeld; rstop = 1'b1;
          end else begin
            act = ActFwd; fwd = 1'b1;
            rel = tail_q;
            grant = tail_q && count_q[oi] != 4'd0 &&
                    qrdata != 4'd0 && qrdata <= 4'(NumInputs);
          end
        end
      end
      OpRaise, OpLower: begin
        rop = port_q;
        if (port_q == 4'd0 || port_q > 4'(NumOutputs)) begin
          act = ActError;
        end else begin
          set_stop = 1'b1;
          if (owner_q[si] == 4'd0 || owner_q[si] > 4'(NumInputs)) begin
            act = ActNothing;
          end else begin
            rip   = owner_q[si];
            act   = (op_q == OpRaise) ? ActStop : ActRelease;
            rstop = (op_q == OpRaise);
          end
        end
      end
      default: act = ActNothing;
    endcase
  end

  assign q_we    = cmd_i.eval && enq;
  assign q_waddr = {oi, tailp};
  assign sts_o.grant = grant;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i; port_q <= port_i; dest_q <= dest_port_i; tail_q <= is_tail_i;
    end
    if (cmd_i.eval) begin
      act1_q <= act; ip1_q <= rip; op1_q <= rop; st1_q <= rstop;
      ip2_q <= qrdata; op2_q <= rop; two_q <= grant;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumOutputs; i++) begin
        owner_q[i] <= '0; head_q[i] <= '0; count_q[i] <= '0; stop_q[i] <= 1'b0;
      end
      for (int i = 0; i < NumInputs; i++) begin
        outof_q[i] <= '0; phase_q[i] <= PhFree;
      end
    end else if (cmd_i.eval) begin
      if (set_stop) stop_q[si] <= (op_q == OpRaise);
      if (enq) begin
        count_q[oi] <= count_q[oi] + QCntW'(1);
        phase_q[pi] <= PhWait;
      end else if (rel) begin
        // free the path; hand the output to the oldest waiter if any
        if (grant) begin
          owner_q[oi] <= qrdata;
          outof_q[ni] <= conn;
          phase_q[ni] <= PhConn;
        end else begin
          owner_q[oi] <= '0;
        end
        outof_q[pi] <= '0;
        phase_q[pi] <= PhFree;
        if (count_q[oi] != '0) begin
          head_q[oi]  <= head_q[oi] + QPtrW'(1);
          count_q[oi] <= count_q[oi] - QCntW'(1);
        end
      end else begin
        if (take) begin
          owner_q[oi] <= port_q;
          outof_q[pi] <= dest_q;
        end
        if (take || fwd) phase_q[pi] <= fwd ? PhConn : PhWait;
      end
    end
  end

  always_comb begin
    if (sel_second_i) begin
      action_o = ActFwd; in_port_o = ip2_q; out_port_o = op2_q;
      input_stop_o = 1'b0; last_o = 1'b1;
    end else begin
      action_o = act1_q; in_port_o = ip1_q; out_port_o = op1_q;
      input_stop_o = st1_q; last_o = !two_q;
    end
  end

endmodule

`default_nettype wire

[src/wormhole_crossbar_allocator_top.sv]
// ----------------------------------------------------------------------------
// wormhole_crossbar_allocator_top: crossbar output allocator for wormhole flits
// Takes flits and output stop events, returns one or two result transfers.
// ----------------------------------------------------------------------------
// One item is handled at a time: the item is captured, the wait-queue RAM
// is read, the item is evaluated, and then each result transfer is held
// for as long as out_stall is high. The registered read of the shared
// wait-queue RAM sets the read step between capture and evaluation.
// Results of a tail that hands the output over come as two transfers; last
// marks the final one. No clearing pass is needed after reset.
`default_nettype none

module wormhole_crossbar_allocator_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] op_i,
  input  wire logic [3:0] port_i,
  input  wire logic [3:0] dest_port_i,
  input  wire logic       is_tail_i,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      action_o,
  output logic [3:0]      in_port_o,
  output logic [3:0]      out_port_o,
  output logic            input_stop_o,
  output logic            last_o
);
  import wca_pkg::*;

  wca_cmd_t cmd;
  wca_sts_t sts;
  logic     sel_second;

  // sequencer: capture, read, evaluate, drain
  wca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .sel_second_o(sel_second)
  );

  // tables, queues and result registers
  wca_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sel_second_i(sel_second),
    .op_i        (op_i),
    .port_i      (port_i),
    .dest_port_i (dest_port_i),
    .is_tail_i   (is_tail_i),
    .action_o    (action_o),
    .in_port_o   (in_port_o),
    .out_port_o  (out_port_o),
    .input_stop_o(input_stop_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire
